// ===== design/bsfe_pkg.sv =====
// Package for the bounded set with oldest-first eviction.
// Holds the word types, command codes, default sizes and controller/datapath links.
// No dependencies.
package bsfe_pkg;

  localparam int DEPTH_DEFAULT     = 256;
  localparam int KEY_WIDTH_DEFAULT = 64;
  localparam int COUNT_OUT_WIDTH   = 9;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_TRIM   = 2'd3
  } command_t;

  typedef struct packed {
    command_t    command;
    logic [63:0] key;
  } req_t;

  typedef struct packed {
    logic                       present;
    logic                       inserted;
    logic [COUNT_OUT_WIDTH-1:0] evicted_count;
    logic [COUNT_OUT_WIDTH-1:0] entry_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

// ===== design/bsfe_datapath.sv =====
// Datapath of the bounded set: key memory ring, scan pipeline, counts and result register.
// Depends on bsfe_pkg.
module bsfe_datapath #(
  parameter int DEPTH     = bsfe_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = bsfe_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wen,
  input  logic [bsfe_pkg::COUNT_OUT_WIDTH-1:0]   cfg_wdata,
  input  bsfe_pkg::req_t                         req,
  input  bsfe_pkg::dp_cmd_t                      cmd,
  output bsfe_pkg::dp_status_t                   status,
  output bsfe_pkg::rsp_t                         rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int OW = bsfe_pkg::COUNT_OUT_WIDTH;

  logic [KEY_WIDTH-1:0] mem [DEPTH];

  logic [OW-1:0]        max_entries;
  logic [AW-1:0]        oldest;
  logic [CW-1:0]        count;
  logic [KEY_WIDTH-1:0] key_reg;
  bsfe_pkg::command_t   cmd_reg;
  logic [AW-1:0]        rd_ptr;
  logic [CW-1:0]        scan_left;
  logic                 issue_valid;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 hit;

  logic [CW-1:0] limit;
  logic          full;
  logic [AW-1:0] tail;
  logic [CW-1:0] count_next;
  logic [AW-1:0] oldest_next;
  logic [CW-1:0] evicted;
  logic          present;
  logic          inserted;
  logic          mem_we;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  // Both operands stay below DEPTH (or equal it), so one subtract folds the sum.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [OW-1:0] to_out(input logic [CW-1:0] x);
    logic [31:0] t;
    t = 32'(x);
    return t[OW-1:0];
  endfunction

  // A limit of zero, or any limit above the capacity, means the full capacity.
  always_comb begin
    if (max_entries == '0 || 32'(max_entries) > 32'(DEPTH)) begin
      limit = CW'(DEPTH);
    end else begin
      limit = CW'(max_entries);
    end
  end

  assign full = (count == limit) || (count >= CW'(DEPTH));
  // The free slot after the newest key; unchanged by evicting the oldest one first.
  assign tail = wrap_add(oldest, count);

  assign status.scan_done = (scan_left == '0) && !issue_valid;

  always_comb begin
    count_next  = count;
    oldest_next = oldest;
    evicted     = '0;
    present     = 1'b0;
    inserted    = 1'b0;
    mem_we      = 1'b0;
    unique case (cmd_reg)
      bsfe_pkg::CMD_INSERT: begin
        present = hit;
        if (!hit) begin
          inserted = 1'b1;
          mem_we   = 1'b1;
          if (full) begin
            oldest_next = wrap_inc(oldest);
            evicted     = CW'(1);
          end else begin
            count_next = count + CW'(1);
          end
        end
      end
      bsfe_pkg::CMD_LOOKUP: begin
        present = hit;
      end
      bsfe_pkg::CMD_CLEAR: begin
        evicted     = count;
        count_next  = '0;
        oldest_next = '0;
      end
      bsfe_pkg::CMD_TRIM: begin
        if (count > limit) begin
          evicted     = count - limit;
          oldest_next = wrap_add(oldest, count - limit);
          count_next  = limit;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= '0;
      oldest      <= '0;
      count       <= '0;
      scan_left   <= '0;
      issue_valid <= 1'b0;
      hit         <= 1'b0;
    end else begin
      if (cfg_wen) begin
        max_entries <= cfg_wdata;
      end
      if (cmd.start) begin
        key_reg     <= req.key[KEY_WIDTH-1:0];
        cmd_reg     <= req.command;
        rd_ptr      <= oldest;
        issue_valid <= 1'b0;
        hit         <= 1'b0;
        if (req.command == bsfe_pkg::CMD_INSERT || req.command == bsfe_pkg::CMD_LOOKUP) begin
          scan_left <= count;
        end else begin
          scan_left <= '0;
        end
      end else if (cmd.scan) begin
        // One read is issued per cycle; its data is compared in the next cycle.
        if (scan_left != '0) begin
          rd_ptr      <= wrap_inc(rd_ptr);
          scan_left   <= scan_left - CW'(1);
          issue_valid <= 1'b1;
        end else begin
          issue_valid <= 1'b0;
        end
        if (issue_valid && rd_data == key_reg) begin
          hit <= 1'b1;
        end
      end
      if (cmd.commit) begin
        count  <= count_next;
        oldest <= oldest_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      mem[tail] <= key_reg;
    end
    rd_data <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.present       <= present;
      rsp.inserted      <= inserted;
      rsp.evicted_count <= to_out(evicted);
      rsp.entry_count   <= to_out(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("stored count above capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan_left <= count)
    else $error("scan runs beyond the stored keys");

  a_commit_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.scan_done)
    else $error("commit while the scan is still running");

  a_insert_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && cmd_reg == bsfe_pkg::CMD_INSERT |=> count != '0)
    else $error("set empty after an insert");

endmodule

// ===== design/bsfe_controller.sv =====
// Controller of the bounded set: sequences accept, scan and commit, and owns result valid.
// Depends on bsfe_pkg.
module bsfe_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  bsfe_pkg::dp_status_t  status,
  output bsfe_pkg::dp_cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;

  assign req_stall  = (state != ST_IDLE);
  assign cmd.start  = req_valid && (state == ST_IDLE);
  assign cmd.scan   = (state == ST_SCAN);
  // The result register must be empty or emptying before a new word lands in it.
  assign cmd.commit = (state == ST_FINISH) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status.scan_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (cmd.commit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == ST_SCAN)
    else $error("accepted word did not start a scan");

  a_commit_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid && state == ST_IDLE)
    else $error("commit did not present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> !cmd.commit)
    else $error("result overwritten while stalled");

endmodule

// ===== design/bounded_set_fifo_eviction_top.sv =====
// Bounded key set with oldest-first eviction. Insert and lookup scan the stored keys, one
// memory read a cycle; clear and trim do not scan. One word is in work at a time; the next
// is taken the cycle after its result is registered, so a stalled result holds it back.
// A finished result waits in an output register while the next word is accepted.
// Synchronous reset empties the set and zeroes the limit; the key memory is not cleared.
module bounded_set_fifo_eviction_top #(
  parameter int DEPTH     = bsfe_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = bsfe_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [bsfe_pkg::COUNT_OUT_WIDTH-1:0] cfg_wdata,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  bsfe_pkg::req_t                       req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output bsfe_pkg::rsp_t                       rsp
);

  bsfe_pkg::dp_cmd_t    cmd;
  bsfe_pkg::dp_status_t status;

  bsfe_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bsfe_datapath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp       (rsp)
  );

endmodule
